### src/llm_pkg.sv
// Shared types, constants and helper functions for the LED level meter and chaser.
`default_nettype none

package llm_pkg;

    localparam int ENERGY_W   = 32;
    localparam int VOLUME_W   = 6;
    localparam int MODE_W     = 2;
    localparam int LED_W      = 5;
    localparam int SIL_CNT_W  = 7;
    localparam int PRESCALE_W = 8;
    localparam int STEP_W     = 5;
    localparam int LEVEL_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BAR_SHIFT  = 12;
    localparam int DIV_IN_W   = ENERGY_W - BAR_SHIFT;
    localparam int DIVISOR_W  = 4;
    localparam int REM5_W     = 3;
    localparam int BITCNT_W   = 5;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASE_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_PERIOD    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHASE = 2'd2;

    localparam logic [LEVEL_W-1:0]    SILENCE_LEVEL_RST = 16'd4096;
    localparam logic [SIL_CNT_W-1:0]  SILENCE_TICKS_RST = 7'd100;
    localparam logic [PRESCALE_W-1:0] CHASE_PERIOD_RST  = 8'd50;
    localparam logic [PRESCALE_W-1:0] BAR_PERIOD_RST    = 8'd8;
    localparam logic [SIL_CNT_W-1:0]  SILENCE_CAP       = 7'd110;
    localparam logic [SIL_CNT_W-1:0]  SILENCE_MAX       = 7'd127;
    localparam logic [STEP_W-1:0]     STEP_IDLE         = 5'd20;
    localparam logic [STEP_W-1:0]     STEP_LAST         = 5'd6;
    localparam logic [VOLUME_W-1:0]   VOLUME_LOW        = 6'd10;
    localparam logic [DIVISOR_W-1:0]  DIVISOR_LOW       = 4'd2;
    localparam logic [REM5_W:0]       FIVE              = 4'd5;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } llm_state_t;

    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] count;
    } llm_div_stat_t;

    function automatic logic [LED_W-1:0] chase_pattern(input logic [STEP_W-1:0] step);
        logic [LED_W-1:0] pat;
        begin
            unique case (step)
                5'd0:    pat = 5'b00001;
                5'd1:    pat = 5'b00010;
                5'd2:    pat = 5'b00100;
                5'd3:    pat = 5'b01000;
                5'd4:    pat = 5'b10000;
                5'd5:    pat = 5'b01010;
                5'd6:    pat = 5'b10100;
                default: pat = '0;
            endcase
            return pat;
        end
    endfunction

    // (volume - 1) / 5 + 1 above the low-volume limit, through a reciprocal of 205 / 1024
    function automatic logic [DIVISOR_W-1:0] bar_divisor(input logic [VOLUME_W-1:0] volume);
        logic [VOLUME_W-1:0] vm1;
        logic [13:0]         prod;
        logic [DIVISOR_W-1:0] res;
        begin
            vm1  = volume - 6'd1;
            prod = 14'(vm1) * 14'd205;
            if (volume > VOLUME_LOW)
                res = prod[13:10] + 4'd1;
            else
                res = DIVISOR_LOW;
            return res;
        end
    endfunction

    function automatic logic [LED_W-1:0] bar_mask(input logic [DIVISOR_W-1:0] count);
        logic [LED_W-1:0] mask;
        begin
            unique case (count)
                4'd0:    mask = 5'b00000;
                4'd1:    mask = 5'b00001;
                4'd2:    mask = 5'b00011;
                4'd3:    mask = 5'b00111;
                4'd4:    mask = 5'b01111;
                4'd5:    mask = 5'b11111;
                default: mask = 5'b00000;
            endcase
            return mask;
        end
    endfunction

endpackage

`default_nettype wire

### src/led_level_meter_chaser_unit.sv
// Top level of the LED level meter and chaser: tick handling, state and output register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: energy, volume, light_mode, standby
//  m_*      out  m_tvalid/m_tready  m_tdata: led_mask
//  cfg_*    in   cfg_we             cfg_addr, cfg_data
//
// A tick without a bar update passes DONE into the output register; a bar update
// also waits in CALC on the bit-serial divide and modulo over the 20 energy bits.
// The next request is taken once the result sits in the output register, even
// while it waits on m_tready. Reset clears all counters but step, and drops m_tvalid.
`default_nettype none

module led_level_meter_chaser_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // [31:0] energy, [37:32] volume, [39:38] light_mode, [40] standby, [47:41] zero
    input  wire logic [llm_pkg::S_DATA_W-1:0]   s_tdata,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [4:0] led_mask, [7:5] zero
    output      logic [llm_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [llm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [llm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import llm_pkg::*;

    llm_state_t            state_reg, state_next;
    logic [LEVEL_W-1:0]    sil_level_reg;
    logic [SIL_CNT_W-1:0]  sil_ticks_reg;
    logic [PRESCALE_W-1:0] chase_period_reg;
    logic [PRESCALE_W-1:0] bar_period_reg;
    logic [SIL_CNT_W-1:0]  sil_cnt_reg, sil_cnt_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [LED_W-1:0]      led_reg, led_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LED_W-1:0]      out_led_reg, out_led_next;

    logic [ENERGY_W-1:0]   energy;
    logic [VOLUME_W-1:0]   volume;
    logic [MODE_W-1:0]     light_mode;
    logic                  standby;
    logic                  accept;
    logic                  silent;
    logic [SIL_CNT_W-1:0]  cnt_inc;
    logic [SIL_CNT_W-1:0]  cnt_sat;
    logic                  no_signal;
    logic [PRESCALE_W-1:0] pre_inc;
    logic [STEP_W-1:0]     step_inc;
    logic                  div_start;
    llm_div_stat_t         div_stat;

    assign energy     = s_tdata[31:0];
    assign volume     = s_tdata[37:32];
    assign light_mode = s_tdata[39:38];
    assign standby    = s_tdata[40];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        silent    = (energy[31:16] == '0) && (energy[15:0] < sil_level_reg);
        cnt_inc   = silent ? ((sil_cnt_reg < SILENCE_MAX) ? sil_cnt_reg + 7'd1 : sil_cnt_reg)
                           : '0;
        cnt_sat   = (cnt_inc > sil_ticks_reg) ? SILENCE_CAP : cnt_inc;
        no_signal = (cnt_sat > sil_ticks_reg);
        pre_inc   = prescale_reg + 8'd1;
        step_inc  = step_reg + 5'd1;

        state_next     = state_reg;
        sil_cnt_next   = sil_cnt_reg;
        prescale_next  = prescale_reg;
        step_next      = step_reg;
        led_next       = led_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_led_next   = out_led_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sil_cnt_next = cnt_sat;
                    state_next   = ST_DONE;
                    if (light_mode == MODE_OFF || standby)
                    begin
                        led_next = '0;
                    end
                    else if (light_mode == MODE_CHASE || no_signal || volume == '0)
                    begin
                        prescale_next = pre_inc;
                        if (pre_inc > chase_period_reg)
                        begin
                            prescale_next = '0;
                            step_next     = (step_inc > STEP_LAST) ? '0 : step_inc;
                            led_next      = chase_pattern((step_inc > STEP_LAST) ? '0
                                                                                 : step_inc);
                        end
                    end
                    else
                    begin
                        step_next     = STEP_IDLE;
                        prescale_next = pre_inc;
                        if (pre_inc > bar_period_reg)
                        begin
                            prescale_next = '0;
                            div_start     = 1'b1;
                            state_next    = ST_CALC;
                        end
                    end
                end
            end
            ST_CALC:
            begin
                if (div_stat.done)
                begin
                    led_next   = bar_mask(div_stat.count);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_led_next   = led_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    llm_bar_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .x       (energy[ENERGY_W-1:BAR_SHIFT]),
        .divisor (bar_divisor(volume)),
        .stat    (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sil_level_reg    <= SILENCE_LEVEL_RST;
            sil_ticks_reg    <= SILENCE_TICKS_RST;
            chase_period_reg <= CHASE_PERIOD_RST;
            bar_period_reg   <= BAR_PERIOD_RST;
            sil_cnt_reg      <= '0;
            prescale_reg     <= '0;
            step_reg         <= STEP_IDLE;
            led_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sil_cnt_reg   <= sil_cnt_next;
            prescale_reg  <= prescale_next;
            step_reg      <= step_next;
            led_reg       <= led_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_SILENCE_LEVEL: sil_level_reg    <= cfg_data;
                    CFG_SILENCE_TICKS: sil_ticks_reg    <= cfg_data[SIL_CNT_W-1:0];
                    CFG_CHASE_PERIOD:  chase_period_reg <= cfg_data[PRESCALE_W-1:0];
                    CFG_BAR_PERIOD:    bar_period_reg   <= cfg_data[PRESCALE_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_led_reg <= out_led_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - LED_W)'(0), out_led_reg};

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("request taken but block stayed idle");

    a_div_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_CALC)
        else $error("divider finished outside the bar calculation");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST || step_reg == STEP_IDLE)
        else $error("chase step out of range");

    a_load_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && (!out_valid_reg || m_tready) |=> m_tvalid)
        else $error("result not presented after completion");

endmodule

`default_nettype wire

### src/llm_bar_div.sv
// Bit-serial divide by five and, in the same pass, modulo of the quotient, one bit per cycle.
`default_nettype none

module llm_bar_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [llm_pkg::DIV_IN_W-1:0]    x,
    input  wire logic [llm_pkg::DIVISOR_W-1:0]   divisor,
    output llm_pkg::llm_div_stat_t               stat
);
    import llm_pkg::*;

    logic [DIV_IN_W-1:0]  shift_reg, shift_next;
    logic [BITCNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM5_W-1:0]    r5_reg, r5_next;
    logic [DIVISOR_W-1:0] rd_reg, rd_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [REM5_W:0]      t5;
    logic                 qbit;
    logic [DIVISOR_W:0]   td;

    always_comb
    begin
        t5   = {r5_reg, shift_reg[DIV_IN_W-1]};
        qbit = (t5 >= FIVE);
        td   = {rd_reg, qbit};

        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        r5_next    = r5_reg;
        rd_next    = rd_reg;
        div_next   = div_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            shift_next = x;
            cnt_next   = '0;
            r5_next    = '0;
            rd_next    = '0;
            div_next   = divisor;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[DIV_IN_W-2:0], 1'b0};
            r5_next    = qbit ? REM5_W'(t5 - FIVE) : t5[REM5_W-1:0];
            rd_next    = (td >= {1'b0, div_reg}) ? DIVISOR_W'(td - {1'b0, div_reg})
                                                 : td[DIVISOR_W-1:0];
            cnt_next   = cnt_reg + 5'd1;
            if (cnt_reg == BITCNT_W'(DIV_IN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        r5_reg    <= r5_next;
        rd_reg    <= rd_next;
        div_reg   <= div_next;
    end

    assign stat.done  = done_reg;
    assign stat.count = rd_reg;

    a_rem5_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> r5_reg < REM5_W'(5))
        else $error("divide-by-five remainder out of range");

    a_remd_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> rd_reg < div_reg)
        else $error("modulo remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished pass");

endmodule

`default_nettype wire
